/* rtl/ffba_pkg.sv */
// shared types, constants and codes for the first-fit block allocator
package ffba_pkg;

  localparam int MaxBlocks = 64;
  localparam int SlotW = $clog2(MaxBlocks);
  localparam int AddrW = 48;
  localparam int SizeW = 33;
  localparam int CountW = $clog2(MaxBlocks + 1);
  localparam logic [SizeW-1:0] PoolSizeReset = SizeW'(128 * 1024 * 1024);

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [SizeW-1:0] size_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_ZERO      = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_POOL_BASE = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic  command;
    size_t alloc_size;
    addr_t free_address;
  } in_item_t;

  typedef struct packed {
    addr_t block_address;
    logic [2:0] status;
  } out_item_t;

  // datapath operations chosen by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_RD,
    OP_SPLIT_A,
    OP_SPLIT_B,
    OP_SET_FREE,
    OP_LD_SUCC,
    OP_WR_BLK,
    OP_WR_PREV,
    OP_TAIL,
    OP_RELEASE
  } op_t;

  typedef struct packed {
    op_t   op;
    slot_t slot;
    slot_t slot_b;
    slot_t link;
    addr_t start;
    size_t free_bytes;
    logic  set_tail;
    slot_t tail_val;
  } dp_cmd_t;

  typedef struct packed {
    addr_t rd_start;
    size_t rd_free;
    slot_t rd_link;
    slot_t tail;
    logic  have_slot;
    slot_t free_slot;
  } dp_stat_t;

endpackage

/* rtl/ffba_datapath.sv */
// block table memories, slot bitmap with free-slot pointer, tail register
module ffba_datapath import ffba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  addr_t    pool_base,
  input  size_t    pool_size,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  addr_t start_mem [MaxBlocks];
  size_t free_mem [MaxBlocks];
  slot_t link_mem [MaxBlocks];
  logic [MaxBlocks-1:0] taken;
  slot_t tail;
  addr_t rd_start;
  size_t rd_free;
  slot_t rd_link;
  slot_t low_free;
  logic any_free;
  logic have_slot;
  slot_t free_slot;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) begin
      start_mem[0] <= pool_base;
      free_mem[0] <= pool_size;
      link_mem[0] <= '0;
    end else if (cmd.op == OP_WR_BLK || cmd.op == OP_SPLIT_B) begin
      start_mem[cmd.slot] <= cmd.start;
      free_mem[cmd.slot] <= cmd.free_bytes;
      link_mem[cmd.slot] <= cmd.link;
    end else if (cmd.op == OP_SET_FREE || cmd.op == OP_SPLIT_A || cmd.op == OP_WR_PREV) begin
      free_mem[cmd.slot] <= cmd.free_bytes;
      link_mem[cmd.slot] <= cmd.link;
    end
    rd_start <= start_mem[cmd.slot];
    rd_free <= free_mem[cmd.slot];
    rd_link <= link_mem[cmd.slot];
  end

  // lowest free slot, registered so the priority search sits off the memory path
  always_comb begin
    low_free = '0;
    any_free = 1'b0;
    for (int i = MaxBlocks - 1; i >= 0; i--) begin
      if (!taken[i]) begin
        low_free = SlotW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_INIT) begin
      taken <= {{(MaxBlocks-1){1'b0}}, 1'b1};
      tail <= '0;
    end else begin
      if (cmd.op == OP_SPLIT_B) taken[cmd.slot] <= 1'b1;
      if (cmd.op == OP_RELEASE) begin
        taken[cmd.slot] <= 1'b0;
        if (cmd.slot_b != cmd.slot) taken[cmd.slot_b] <= 1'b0;
      end
      if (cmd.set_tail) tail <= cmd.tail_val;
    end
    have_slot <= any_free;
    free_slot <= low_free;
  end

  assign stat.rd_start = rd_start;
  assign stat.rd_free = rd_free;
  assign stat.rd_link = rd_link;
  assign stat.tail = tail;
  assign stat.have_slot = have_slot;
  assign stat.free_slot = free_slot;

endmodule

/* rtl/ffba_controller.sv */
// sequencer for allocate and free list walks
module ffba_controller import ffba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  addr_t     cfg_data,
  output addr_t     pool_base,
  output size_t     pool_size,
  output dp_cmd_t   cmd,
  input  dp_stat_t  stat
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SETTLE,
    S_A_TAIL, S_A_TAIL_W, S_A_TAIL_SPLIT,
    S_A_WALK_CUR, S_A_WALK_CUR_W, S_A_WALK_NXT, S_A_WALK_NXT_W, S_A_FIT,
    S_A_SPLIT2,
    S_F_PREV, S_F_PREV_W, S_F_BLK, S_F_BLK_W, S_F_SUCC, S_F_SUCC_W,
    S_F_ACT, S_F_REL, S_DONE
  } state_t;

  state_t state;
  logic cmd_q;
  size_t size_q;
  addr_t addr_q;
  slot_t cur, nxt, prev, blk, succ, ns_q;
  addr_t cur_start, blk_start, succ_start;
  size_t cur_free, prev_free, succ_free;
  slot_t cur_link, succ_link;
  logic [CountW-1:0] count;
  size_t blk_bytes;
  logic mp, mn;
  logic mp_q, mn_q;

  assign in_ready = (state == S_IDLE) && !out_valid && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !out_valid;

  assign blk_bytes = SizeW'(succ_start - blk_start);
  assign mp = (prev_free != '0) && (prev != stat.tail);
  assign mn = (succ_free != '0) || (succ == stat.tail);

  always_comb begin
    cmd = '0;
    cmd.op = OP_NONE;
    unique case (state)
      S_INIT: cmd.op = OP_INIT;
      S_A_TAIL, S_F_PREV: cmd.slot = stat.tail;
      S_A_TAIL_SPLIT: begin
        cmd.op = OP_SPLIT_A; cmd.slot = cur; cmd.free_bytes = '0; cmd.link = ns_q;
      end
      S_A_WALK_CUR: cmd.slot = cur;
      S_A_WALK_NXT: cmd.slot = nxt;
      S_A_SPLIT2: begin
        cmd.op = OP_SPLIT_B; cmd.slot = ns_q; cmd.link = cur_link;
        cmd.free_bytes = cur_free - size_q; cmd.start = cur_start + AddrW'(size_q);
        cmd.set_tail = (state == S_A_SPLIT2) && (cur == stat.tail);
        cmd.tail_val = ns_q;
      end
      S_A_FIT: begin
        cmd.op = OP_SPLIT_A; cmd.slot = nxt; cmd.free_bytes = '0;
        cmd.link = (cur_free > size_q) ? ns_q : cur_link;
      end
      S_F_BLK: cmd.slot = blk;
      S_F_SUCC: cmd.slot = succ;
      S_F_ACT: begin
        if (mp && mn) begin
          cmd.op = OP_WR_PREV; cmd.slot = prev; cmd.link = succ_link;
          cmd.free_bytes = prev_free + succ_free + blk_bytes;
          cmd.set_tail = (succ == stat.tail); cmd.tail_val = prev;
        end else if (mp) begin
          cmd.op = OP_WR_PREV; cmd.slot = prev; cmd.link = succ;
          cmd.free_bytes = prev_free + blk_bytes;
        end else if (mn) begin
          cmd.op = OP_SET_FREE; cmd.slot = blk; cmd.link = succ_link;
          cmd.free_bytes = blk_bytes + succ_free;
          cmd.set_tail = (succ == stat.tail); cmd.tail_val = blk;
        end else begin
          cmd.op = OP_SET_FREE; cmd.slot = blk; cmd.link = succ; cmd.free_bytes = blk_bytes;
        end
      end
      S_F_REL: begin
        cmd.op = OP_RELEASE;
        cmd.slot = mp_q ? blk : succ;
        cmd.slot_b = (mp_q && mn_q) ? succ : (mp_q ? blk : succ);
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
      pool_base <= '0;
      pool_size <= PoolSizeReset;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_POOL_BASE) pool_base <= cfg_data;
            else pool_size <= SizeW'(cfg_data);
            state <= S_INIT;
          end else if (in_valid && in_ready) begin
            cmd_q <= in_data.command;
            size_q <= in_data.alloc_size;
            addr_q <= in_data.free_address;
            out_data <= '0;
            state <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          ns_q <= stat.free_slot;
          count <= '0;
          if (cmd_q == CMD_FREE) state <= S_F_PREV;
          else if (size_q == '0) begin
            out_data.status <= ST_ZERO; state <= S_DONE;
          end else state <= S_A_TAIL;
        end
        S_A_TAIL: begin cur <= stat.tail; state <= S_A_TAIL_W; end
        S_A_TAIL_W: begin
          cur_free <= stat.rd_free; cur_start <= stat.rd_start; cur_link <= stat.rd_link;
          if (stat.rd_free >= size_q) begin
            if (!stat.have_slot) begin
              out_data.status <= ST_FULL; state <= S_DONE;
            end else begin
              out_data.block_address <= stat.rd_start;
              state <= S_A_TAIL_SPLIT;
            end
          end else state <= S_A_WALK_CUR;
        end
        S_A_TAIL_SPLIT: state <= S_A_SPLIT2;
        S_A_WALK_CUR: state <= S_A_WALK_CUR_W;
        S_A_WALK_CUR_W: begin nxt <= stat.rd_link; state <= S_A_WALK_NXT; end
        S_A_WALK_NXT: state <= S_A_WALK_NXT_W;
        S_A_WALK_NXT_W: begin
          count <= count + 1'b1;
          cur_free <= stat.rd_free; cur_start <= stat.rd_start; cur_link <= stat.rd_link;
          if (stat.rd_free >= size_q) begin
            if (stat.rd_free > size_q && !stat.have_slot) begin
              out_data.status <= ST_FULL; state <= S_DONE;
            end else begin
              out_data.block_address <= stat.rd_start;
              state <= S_A_FIT;
            end
          end else if (nxt == stat.tail || count == CountW'(MaxBlocks - 1)) begin
            out_data.status <= ST_NO_FIT; state <= S_DONE;
          end else begin
            cur <= nxt; state <= S_A_WALK_CUR;
          end
        end
        S_A_FIT: begin
          cur <= nxt;
          state <= (cur_free > size_q) ? S_A_SPLIT2 : S_DONE;
        end
        S_A_SPLIT2: state <= S_DONE;
        S_F_PREV: begin prev <= stat.tail; state <= S_F_PREV_W; end
        S_F_PREV_W: begin
          prev_free <= stat.rd_free;
          blk <= stat.rd_link;
          count <= count + 1'b1;
          if (stat.rd_link == stat.tail || count == CountW'(MaxBlocks)) begin
            out_data.status <= ST_NOT_FOUND; state <= S_DONE;
          end else state <= S_F_BLK;
        end
        S_F_BLK: state <= S_F_BLK_W;
        S_F_BLK_W: begin
          blk_start <= stat.rd_start;
          succ <= stat.rd_link;
          if (stat.rd_start == addr_q) state <= S_F_SUCC;
          else begin
            prev <= blk; prev_free <= stat.rd_free;
            blk <= stat.rd_link;
            count <= count + 1'b1;
            if (stat.rd_link == stat.tail || count == CountW'(MaxBlocks)) begin
              out_data.status <= ST_NOT_FOUND; state <= S_DONE;
            end else state <= S_F_BLK;
          end
        end
        S_F_SUCC: state <= S_F_SUCC_W;
        S_F_SUCC_W: begin
          succ_start <= stat.rd_start; succ_free <= stat.rd_free; succ_link <= stat.rd_link;
          state <= S_F_ACT;
        end
        S_F_ACT: begin
          // merge choice held before the tail moves
          mp_q <= mp;
          mn_q <= mn;
          state <= (mp || mn) ? S_F_REL : S_DONE;
        end
        S_F_REL: state <= S_DONE;
        S_DONE: begin out_valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/first_fit_block_allocator_unit.sv */
// zero-size and tail allocates need no list walk; an allocate walk reads the current and next
// block for each block visited, and a free lookup reads one block for each block visited
// one request at a time; the next is taken once the result beat has left
// the table walk through the single-port block memories sets the rate
// synchronous reset, and any configuration write, restores one free block over the pool
// the result register holds a finished beat while the output side stalls
module first_fit_block_allocator_unit import ffba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  addr_t     cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  addr_t    pool_base;
  size_t    pool_size;

  ffba_controller u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pool_base, .pool_size,
    .cmd, .stat
  );

  ffba_datapath u_dp (
    .clk, .rst, .pool_base, .pool_size, .cmd, .stat
  );

endmodule
